[hdl/zee_pkg.sv]
// zee_pkg: shared types, constants and helper functions for the zone expander emulator
`timescale 1ns / 1ps

package zee_pkg;

	localparam int NUM_MODULES = 7;

	typedef logic [2:0] slot_t;
	typedef logic [6:0] cfg_data_t;
	typedef logic [0:0] cfg_idx_t;

	// configuration register indexes
	localparam cfg_idx_t CFG_MAX_ZONES     = 1'b0;
	localparam cfg_idx_t CFG_MODULE_ENABLE = 1'b1;

	// item opcodes
	localparam logic OP_SET_FAULT = 1'b0;
	localparam logic OP_QUERY     = 1'b1;

	localparam cfg_data_t    MAX_ZONES_RESET = 7'd32;
	localparam cfg_data_t    ENABLE_RESET    = 7'd0;
	localparam cfg_data_t    HIGH_SLOT_ZONES = 7'd32;
	localparam slot_t        FIRST_HIGH_SLOT = 3'd3;
	localparam logic [7:0]   ZONE_FIRST      = 8'd9;
	localparam logic [7:0]   ZONE_LAST       = 8'd64;
	localparam logic [7:0]   FIELD_RESET     = 8'h55;
	localparam logic [7:0]   BYTE_IDLE       = 8'hFF;
	localparam logic [3:0]   NIB_IDLE        = 4'hF;
	localparam logic [39:0]  RESP_RESET      = 40'hAA_00_55_00_55;
	localparam logic [2:0]   UPD_IDX_LOW     = 3'd2;
	localparam logic [2:0]   UPD_IDX_HIGH    = 3'd5;

	typedef struct packed {
		logic       op;
		logic [7:0] zone;
		logic       fault;
		logic [7:0] address;
	} in_item_t;

	typedef struct packed {
		logic       response_valid;
		logic [7:0] resp_byte0;
		logic [7:0] resp_byte1;
		logic [7:0] resp_byte2;
		logic [7:0] resp_byte3;
		logic [7:0] resp_byte4;
		logic       update_request;
		logic [2:0] update_index;
		logic [7:0] update_mask;
	} out_item_t;

	typedef struct packed {
		logic  hit;
		slot_t slot;
	} slot_dec_t;

	// bus address to module slot
	function automatic slot_dec_t addr_to_slot(input logic [7:0] addr);
		slot_dec_t d;
		d.hit = 1'b1;
		unique case (addr)
			8'd9:    d.slot = 3'd0;
			8'd10:   d.slot = 3'd1;
			8'd11:   d.slot = 3'd2;
			8'd12:   d.slot = 3'd3;
			8'd13:   d.slot = 3'd4;
			8'd14:   d.slot = 3'd5;
			8'd16:   d.slot = 3'd6;
			default: begin
				d.hit  = 1'b0;
				d.slot = 3'd0;
			end
		endcase
		return d;
	endfunction

	function automatic logic slot_active(input cfg_data_t en, input cfg_data_t mz,
	                                     input slot_t s);
		return (s < slot_t'(NUM_MODULES)) && en[s] && ((s < FIRST_HIGH_SLOT) || (mz > HIGH_SLOT_ZONES));
	endfunction

	function automatic logic [2:0] slot_upd_index(input slot_t s);
		return (s < FIRST_HIGH_SLOT) ? UPD_IDX_LOW : UPD_IDX_HIGH;
	endfunction

	// zero bit marks the module in the status byte
	function automatic logic [7:0] slot_upd_mask(input slot_t s);
		logic [7:0] m;
		unique case (s)
			3'd0:    m = 8'hbf;
			3'd1:    m = 8'hdf;
			3'd2:    m = 8'hef;
			3'd3:    m = 8'h7f;
			3'd4:    m = 8'hbf;
			3'd5:    m = 8'hdf;
			3'd6:    m = 8'hef;
			default: m = BYTE_IDLE;
		endcase
		return m;
	endfunction

	// open sets both code bits, close clears the upper one
	function automatic logic [7:0] set_code(input logic [7:0] b, input logic [1:0] chan,
	                                        input logic fault);
		logic [7:0] open_m;
		logic [7:0] close_m;
		open_m  = 8'h03 << {chan, 1'b0};
		close_m = 8'h02 << {chan, 1'b0};
		return fault ? (b | open_m) : (b & ~close_m);
	endfunction

	function automatic logic [3:0] nib_sum(input logic [7:0] a, input logic [7:0] b);
		logic [5:0] s;
		s = 6'(a[7:4]) + 6'(a[3:0]) + 6'(b[7:4]) + 6'(b[3:0]);
		return s[3:0];
	endfunction

endpackage

[hdl/zone_expander_emulator.sv]
// zone_expander_emulator: top level, seven emulated 8-zone expander modules
`timescale 1ns / 1ps

// usage
// - item channel: drive item and pulse start; an item is taken at every edge with
//   start high and busy low; busy is always low, so one item per clock is taken
// - result channel: done is high for one cycle with the result on result; the
//   receiver cannot stall, so every result must be captured in that cycle
// - timing: an item is taken into the input register, and its result is built from
//   that register and taken into the result register; throughput is one item per
//   cycle, set by the read-modify-write of one module record from the input register
// - a set-fault item updates the channel code, rebuilds the module's fault
//   response and raises update_request when the zone data changed
// - a query item returns the stored response of an enabled module
// - config: cfg_we writes cfg_data into register cfg_index (0 max_zones,
//   1 module_enable); write only while no item is in flight
// - reset: max_zones 32, all modules disabled, channel codes 0x55, responses
//   55 00 55 00 aa; no clearing pass, the block takes items right after reset
module zone_expander_emulator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  zee_pkg::in_item_t  item,
	output logic               done,
	output zee_pkg::out_item_t result,
	input  logic               cfg_we,
	input  zee_pkg::cfg_idx_t  cfg_index,
	input  zee_pkg::cfg_data_t cfg_data
);
	import zee_pkg::*;

	// configuration
	cfg_data_t max_zones_q;
	cfg_data_t module_enable_q;

	// input register
	logic     valid_s1;
	in_item_t item_s1;

	// module records: current low and high channel bytes; previous always
	// equals current once an item completes, so it is not stored apart
	logic [7:0]  lo_q   [NUM_MODULES];
	logic [7:0]  hi_q   [NUM_MODULES];
	logic [39:0] resp_q [NUM_MODULES];

	// result register
	logic      done_q;
	out_item_t result_q;

	logic       accept;
	slot_dec_t  q_dec;
	logic       q_hit;
	logic [7:0] rel;
	slot_t      set_slot;
	logic [2:0] chan;
	logic       zone_ok;
	logic       set_ok;
	logic [7:0] old_lo;
	logic [7:0] old_hi;
	logic [7:0] new_lo;
	logic [7:0] new_hi;
	logic       change_lo;
	logic       change_hi;
	logic [39:0] rsp_new;
	logic [39:0] rsp_rd;
	out_item_t  result_d;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_zones_q     <= MAX_ZONES_RESET;
			module_enable_q <= ENABLE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_ZONES:     max_zones_q     <= cfg_data;
				CFG_MODULE_ENABLE: module_enable_q <= cfg_data;
				default:           max_zones_q     <= max_zones_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// query decode
	assign q_dec  = addr_to_slot(item_s1.address);
	assign q_hit  = q_dec.hit && slot_active(module_enable_q, max_zones_q, q_dec.slot);
	assign rsp_rd = resp_q[q_dec.slot];

	// set decode: zones 9..64 map to eight channels per module
	assign rel      = item_s1.zone - ZONE_FIRST;
	assign set_slot = rel[5:3];
	assign chan     = rel[2:0];
	assign zone_ok  = (item_s1.zone >= ZONE_FIRST) && (item_s1.zone <= ZONE_LAST)
	                  && (item_s1.zone <= {1'b0, max_zones_q});
	assign set_ok   = (item_s1.op == OP_SET_FAULT) && zone_ok
	                  && slot_active(module_enable_q, max_zones_q, set_slot);

	assign old_lo = lo_q[set_slot];
	assign old_hi = hi_q[set_slot];
	// channels 0..3 live in the low byte, 4..7 in the high byte
	assign new_lo = chan[2] ? old_lo : set_code(old_lo, chan[1:0], item_s1.fault);
	assign new_hi = chan[2] ? set_code(old_hi, chan[1:0], item_s1.fault) : old_hi;

	assign change_lo = (new_lo != old_lo);
	assign change_hi = (new_hi != old_hi);

	// rebuilt response: unchanged pairs and their checksum nibble read as all ones
	always_comb begin
		rsp_new[7:0]   = change_lo ? new_lo : BYTE_IDLE;
		rsp_new[15:8]  = change_lo ? old_lo : BYTE_IDLE;
		rsp_new[23:16] = change_hi ? new_hi : BYTE_IDLE;
		rsp_new[31:24] = change_hi ? old_hi : BYTE_IDLE;
		rsp_new[39:36] = change_lo ? nib_sum(new_lo, old_lo) : NIB_IDLE;
		rsp_new[35:32] = change_hi ? nib_sum(new_hi, old_hi) : NIB_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_MODULES; i++) begin
				lo_q[i]   <= FIELD_RESET;
				hi_q[i]   <= FIELD_RESET;
				resp_q[i] <= RESP_RESET;
			end
		end else if (valid_s1 && set_ok) begin
			lo_q[set_slot]   <= new_lo;
			hi_q[set_slot]   <= new_hi;
			resp_q[set_slot] <= rsp_new;
		end
	end

	// result fields not used by the item's op stay zero
	always_comb begin
		result_d = '0;
		if (item_s1.op == OP_QUERY) begin
			if (q_hit) begin
				result_d.response_valid = 1'b1;
				result_d.resp_byte0     = rsp_rd[7:0];
				result_d.resp_byte1     = rsp_rd[15:8];
				result_d.resp_byte2     = rsp_rd[23:16];
				result_d.resp_byte3     = rsp_rd[31:24];
				result_d.resp_byte4     = rsp_rd[39:32];
			end
		end else if (set_ok && (change_lo || change_hi)) begin
			result_d.update_request = 1'b1;
			result_d.update_index   = slot_upd_index(set_slot);
			result_d.update_mask    = slot_upd_mask(set_slot);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	// every taken item yields exactly one result, through the input and result registers
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("taken item produced no result");

	a_no_stray_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 2))
		else $error("result without a taken item");

	a_update_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.update_request |->
			!result.response_valid
			&& (result.update_index == UPD_IDX_LOW || result.update_index == UPD_IDX_HIGH))
		else $error("malformed update request");
`endif

endmodule
